// ----- design/tksl_pkg.sv -----
// tksl_pkg: shared types and constants for the top-k score list
// holds the command codes, field widths and the queued command record
// no dependencies
`default_nettype none

package tksl_pkg;

  // field widths of the item and result ports
  localparam int ACTION_W = 2;
  localparam int DOC_W    = 20;
  localparam int SCORE_W  = 32;
  localparam int RANK_W   = 4;

  // action codes on the input port
  localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    OP_UPDATE,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic [DOC_W-1:0]          doc;
    logic signed [SCORE_W-1:0] score;
  } cmd_t;

endpackage

`default_nettype wire

// ----- design/top_k_score_list.sv -----
// top_k_score_list: accepted commands pass through the queue to the back end;
// an entering update is done as remove then insert, a dropped update or a clear
// in the idle state, and a read-out enters the read state, then gives one result per
// cycle for n entries (one if empty). The back end takes no new command until done.
// Reset (asynchronous, active low) empties the list and the two-entry queue;
// results are strobed for one cycle and the receiver cannot stall them.
`default_nettype none

module top_k_score_list #(
  parameter int LIST_DEPTH  = 16,
  parameter int DOC_ID_BITS = 20
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [tksl_pkg::ACTION_W-1:0]        action_i,
  input  wire logic [tksl_pkg::DOC_W-1:0]           doc_id_i,
  input  wire logic signed [tksl_pkg::SCORE_W-1:0]  score_i,
  output logic                                      out_valid_o,
  output logic [tksl_pkg::RANK_W-1:0]               rank_o,
  output logic                                      valid_res_o,
  output logic [tksl_pkg::DOC_W-1:0]                doc_out_o,
  output logic signed [tksl_pkg::SCORE_W-1:0]       score_out_o,
  output logic                                      last_o
);

  tksl_pkg::cmd_t head;
  logic           head_valid;
  logic           pop;

  // front: accept, decode and queue
  tksl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .doc_id_i     (doc_id_i),
    .score_i      (score_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  // back: list maintenance and read-out
  tksl_back #(
    .LIST_DEPTH  (LIST_DEPTH),
    .DOC_ID_BITS (DOC_ID_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .rank_o       (rank_o),
    .valid_res_o  (valid_res_o),
    .doc_out_o    (doc_out_o),
    .score_out_o  (score_out_o),
    .last_o       (last_o)
  );

  // empty-list marker is a single final result at rank zero
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> last_o && (rank_o == '0))
    else $error("empty read-out result malformed");

  // a read-out run has no gaps
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |=> out_valid_o && valid_res_o)
    else $error("read-out run interrupted");

  // ranks step by one inside a run
  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |=> rank_o == tksl_pkg::RANK_W'($past(rank_o) + 1'b1))
    else $error("rank did not advance by one");

endmodule

`default_nettype wire

// ----- design/tksl_front.sv -----
// tksl_front: accepts items, classifies the action and queues commands
// depends on tksl_pkg for the command record and action codes
`default_nettype none

module tksl_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [tksl_pkg::ACTION_W-1:0]        action_i,
  input  wire logic [tksl_pkg::DOC_W-1:0]           doc_id_i,
  input  wire logic signed [tksl_pkg::SCORE_W-1:0]  score_i,
  output tksl_pkg::cmd_t                            head_o,
  output logic                                      head_valid_o,
  input  wire logic                                 pop_i
);

  tksl_pkg::cmd_t               fifo_q [tksl_pkg::Q_DEPTH];
  logic [tksl_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [tksl_pkg::Q_CNT_W-1:0] cnt_q;
  tksl_pkg::cmd_t               cmd;
  logic                         keep;
  logic                         push;
  logic                         pop;

  // decode the action; unknown codes are accepted and dropped
  always_comb begin
    cmd.doc   = doc_id_i;
    cmd.score = score_i;
    cmd.op    = tksl_pkg::OP_UPDATE;
    keep      = 1'b1;
    unique case (action_i)
      tksl_pkg::ACT_UPDATE: cmd.op = tksl_pkg::OP_UPDATE;
      tksl_pkg::ACT_READ:   cmd.op = tksl_pkg::OP_READ;
      tksl_pkg::ACT_CLEAR:  cmd.op = tksl_pkg::OP_CLEAR;
      default:              keep   = 1'b0;
    endcase
  end

  assign busy         = (cnt_q == tksl_pkg::Q_CNT_W'(tksl_pkg::Q_DEPTH));
  assign push         = start && !busy && keep;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = fifo_q[rd_ptr_q];

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd;
  end

endmodule

`default_nettype wire

// ----- design/tksl_back.sv -----
// tksl_back: sorted list of scored documents, update, clear and read-out
// depends on tksl_pkg; takes commands from the front queue
`default_nettype none

module tksl_back #(
  parameter int LIST_DEPTH  = 16,
  parameter int DOC_ID_BITS = 20
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tksl_pkg::cmd_t                       head_i,
  input  wire logic                                 head_valid_i,
  output logic                                      pop_o,
  output logic                                      out_valid_o,
  output logic [tksl_pkg::RANK_W-1:0]               rank_o,
  output logic                                      valid_res_o,
  output logic [tksl_pkg::DOC_W-1:0]                doc_out_o,
  output logic signed [tksl_pkg::SCORE_W-1:0]       score_out_o,
  output logic                                      last_o
);

  localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int KEEP_W = (DOC_ID_BITS < tksl_pkg::DOC_W) ? DOC_ID_BITS : tksl_pkg::DOC_W;
  localparam int DW     = tksl_pkg::DOC_W;
  localparam int SW     = tksl_pkg::SCORE_W;
  localparam int RX_W   = IDX_W + tksl_pkg::RANK_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_READ
  } state_e;

  state_e                 state_q;
  logic [IDX_W-1:0]       rd_q;
  logic [KEEP_W-1:0]      cmd_doc_q;
  logic signed [SW-1:0]   cmd_score_q;

  logic [KEEP_W-1:0]      doc_q   [LIST_DEPTH];
  logic signed [SW-1:0]   score_q [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]  valid_q;
  logic [KEEP_W-1:0]      doc_d   [LIST_DEPTH];
  logic signed [SW-1:0]   score_d [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]  valid_d;

  logic [KEEP_W-1:0]      hd_doc;
  logic [LIST_DEPTH-1:0]  match;
  logic [LIST_DEPTH-1:0]  after_m;
  logic [LIST_DEPTH-1:0]  pos;
  logic [LIST_DEPTH-1:0]  at_m;
  logic [LIST_DEPTH-1:0]  vnext;
  logic                   found;
  logic                   full;
  logic                   beats;
  logic                   is_last;
  logic [RX_W-1:0]        rank_ext;

  assign hd_doc   = head_i.doc[KEEP_W-1:0];
  assign pop_o    = (state_q == ST_IDLE) && head_valid_i;
  assign vnext    = valid_q >> 1;
  assign is_last  = !vnext[rd_q];
  assign rank_ext = RX_W'(rd_q);

  // removal search: matching entry and everything at or behind it
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      match[i] = valid_q[i] && (doc_q[i] == hd_doc);
    end
    after_m[0] = match[0];
    for (int i = 1; i < LIST_DEPTH; i++) begin
      after_m[i] = after_m[i-1] || match[i];
    end
  end

  assign found = |match;
  assign full  = valid_q[LIST_DEPTH-1];
  assign beats = head_i.score > score_q[LIST_DEPTH-1];

  // insertion search: first free slot or first strictly lower score
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      pos[i] = !valid_q[i] || (score_q[i] < cmd_score_q);
    end
    at_m[0] = pos[0];
    for (int i = 1; i < LIST_DEPTH; i++) begin
      at_m[i] = pos[i] && !pos[i-1];
    end
  end

  // next list contents
  always_comb begin
    doc_d   = doc_q;
    score_d = score_q;
    valid_d = valid_q;
    case (state_q)
      ST_IDLE: begin
        if (head_valid_i && head_i.op == tksl_pkg::OP_CLEAR) begin
          valid_d = '0;
        end else if (head_valid_i && head_i.op == tksl_pkg::OP_UPDATE) begin
          if (found) begin
            // close the gap left by the listed document
            for (int i = 0; i < LIST_DEPTH - 1; i++) begin
              if (after_m[i]) begin
                doc_d[i]   = doc_q[i+1];
                score_d[i] = score_q[i+1];
                valid_d[i] = valid_q[i+1];
              end
            end
            valid_d[LIST_DEPTH-1] = 1'b0;
          end else if (full && beats) begin
            // last entry drops out
            valid_d[LIST_DEPTH-1] = 1'b0;
          end
        end
      end
      ST_INSERT: begin
        if (at_m[0]) begin
          doc_d[0]   = cmd_doc_q;
          score_d[0] = cmd_score_q;
          valid_d[0] = 1'b1;
        end
        for (int i = 1; i < LIST_DEPTH; i++) begin
          if (at_m[i]) begin
            doc_d[i]   = cmd_doc_q;
            score_d[i] = cmd_score_q;
            valid_d[i] = 1'b1;
          end else if (pos[i]) begin
            doc_d[i]   = doc_q[i-1];
            score_d[i] = score_q[i-1];
            valid_d[i] = valid_q[i-1];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // list storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    doc_q   <= doc_d;
    score_q <= score_d;
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_q        <= '0;
      cmd_doc_q   <= '0;
      cmd_score_q <= '0;
      out_valid_o <= 1'b0;
      rank_o      <= '0;
      valid_res_o <= 1'b0;
      doc_out_o   <= '0;
      score_out_o <= '0;
      last_o      <= 1'b0;
    end else begin
      out_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            unique case (head_i.op)
              tksl_pkg::OP_UPDATE: begin
                if (found || !full || beats) begin
                  state_q     <= ST_INSERT;
                  cmd_doc_q   <= hd_doc;
                  cmd_score_q <= head_i.score;
                end
              end
              tksl_pkg::OP_READ: begin
                state_q <= ST_READ;
                rd_q    <= '0;
              end
              tksl_pkg::OP_CLEAR: begin
              end
              default: begin
              end
            endcase
          end
        end
        ST_INSERT: begin
          state_q <= ST_IDLE;
        end
        ST_READ: begin
          out_valid_o <= 1'b1;
          if (!valid_q[0]) begin
            // empty list gives a single marker result
            rank_o      <= '0;
            valid_res_o <= 1'b0;
            doc_out_o   <= '0;
            score_out_o <= '0;
            last_o      <= 1'b1;
            state_q     <= ST_IDLE;
          end else begin
            rank_o      <= rank_ext[tksl_pkg::RANK_W-1:0];
            valid_res_o <= 1'b1;
            doc_out_o   <= DW'(doc_q[rd_q]);
            score_out_o <= score_q[rd_q];
            last_o      <= is_last;
            if (is_last) begin
              state_q <= ST_IDLE;
            end else begin
              rd_q <= rd_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
